[design/attn_pkg.sv]
// Shared types, sizes and constant tables for the attention row block.
// Depends on nothing; every other design file but attn_ram imports it.
package attn_pkg;

  localparam int MAX_LEN = 256;
  localparam int MAX_DIM = 64;
  localparam int LEN_W   = $clog2(MAX_LEN);
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int KV_AW   = LEN_W + DIM_W;

  localparam int SAMPLE_W = 16;
  localparam int SCORE_W  = 32;
  localparam int WGT_W    = 17;
  localparam int ACC_W    = 42;
  localparam int RS_W     = 17;
  localparam int DEN_W    = 25;
  localparam int DIVN_W   = 43;
  localparam int SEQ_W    = 9;
  localparam int HDIM_W   = 7;

  localparam int IN_W  = 32;
  localparam int OUT_W = 24;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  typedef enum logic [1:0] {
    OP_LOAD_Q = 2'd0,
    OP_LOAD_K = 2'd1,
    OP_LOAD_V = 2'd2,
    OP_COMPUTE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_SEQ_LEN  = 2'd0,
    REG_HEAD_DIM = 2'd1,
    REG_CAUSAL   = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT,
    ST_SC_LO,
    ST_SC_HI,
    ST_SC_WR,
    ST_W_RD,
    ST_W_DAT,
    ST_W_EXP,
    ST_OUT,
    ST_DIV_LD,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef logic [WGT_W-1:0] exp_tab_t [17];
  typedef logic [RS_W-1:0]  rs_tab_t  [MAX_DIM];

  localparam exp_tab_t EXP2_TAB = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

  // floor(sqrt(floor(2^32 / dim))) for dim = 1 .. MAX_DIM, built at elaboration;
  // r*r <= floor(2^32 / dim) holds exactly when r*r*dim <= 2^32
  function automatic rs_tab_t build_rs_tab();
    rs_tab_t   t;
    longint    r;
    longint    c;
    for (int i = 0; i < MAX_DIM; i++) begin
      r = 0;
      for (int b = 16; b >= 0; b--) begin
        c = r | (64'sd1 <<< b);
        if (c * c * longint'(i + 1) <= 64'sd4294967296) r = c;
      end
      t[i] = RS_W'(r);
    end
    return t;
  endfunction

  localparam rs_tab_t RS_TAB = build_rs_tab();

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

[design/attention_row_softmax.sv]
// Top level: one query row of causal-capable scaled dot-product attention.
// Depends on attn_pkg, attn_ram (query, key, value and score stores) and attn_div.
//
//  channel | direction | handshake        | payload
//  s_*     | in        | tvalid/tready    | tdata: operation, position, dim_index, sample
//  m_*     | out       | tvalid/tready    | tdata: out_value, out_dim; tlast: last
//  cfg_*   | in        | cfg_valid/ready  | cfg_index, cfg_data
//
// A load word is written as it is taken; loads can follow each other every cycle while idle.
// A compute word is worked through by the single multiply-accumulate pipe,
// which walks the key and value stores one element a cycle, and by the
// bit-serial divider. s_tready is low for that whole walk.
// Reset clears control state only; stores hold garbage until loaded.
// A stalled m_tready holds the result word and the walk waits on it.
module attention_row_softmax import attn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // operation[1:0], position[9:2], dim_index[15:10], sample[31:16]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // out_value[15:0], out_dim[21:16], zero[23:22]
  output logic             m_tlast,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [SEQ_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [SEQ_W-1:0]  seq_len;
  logic [HDIM_W-1:0] head_dim;
  logic              causal_mode;

  op_t                 in_op;
  logic [LEN_W-1:0]    in_pos;
  logic [DIM_W-1:0]    in_dim;
  logic [SAMPLE_W-1:0] in_sample;
  logic                s_acc;

  assign in_op     = op_t'(s_tdata[1:0]);
  assign in_pos    = s_tdata[9:2];
  assign in_dim    = s_tdata[15:10];
  assign in_sample = s_tdata[31:16];
  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len     <= SEQ_W'(MAX_LEN);
      head_dim    <= HDIM_W'(MAX_DIM);
      causal_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_SEQ_LEN:  seq_len     <= cfg_data;
        REG_HEAD_DIM: head_dim    <= cfg_data[HDIM_W-1:0];
        REG_CAUSAL:   causal_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp registers to usable last indexes
  logic [LEN_W-1:0] len_m1;
  logic [DIM_W-1:0] dim_m1;
  always_comb begin
    if (seq_len == '0) len_m1 = '0;
    else if (seq_len > SEQ_W'(MAX_LEN)) len_m1 = LEN_W'(MAX_LEN - 1);
    else len_m1 = LEN_W'(seq_len - 1'b1);
    if (head_dim == '0) dim_m1 = '0;
    else if (head_dim > HDIM_W'(MAX_DIM)) dim_m1 = DIM_W'(MAX_DIM - 1);
    else dim_m1 = DIM_W'(head_dim - 1'b1);
  end

  logic [LEN_W-1:0] qpos;
  logic [LEN_W-1:0] j;
  logic [DIM_W-1:0] d;
  logic [LEN_W-1:0] icnt;
  logic             issuing;
  logic             v1, l1, v2, l2;
  logic             out_phase;
  logic             ilast;

  assign out_phase = (state == ST_OUT);
  assign ilast     = out_phase ? (icnt == len_m1) : (icnt[DIM_W-1:0] == dim_m1);

  // stores
  logic [SAMPLE_W-1:0] q_rd, k_rd, v_rd;
  logic [SCORE_W-1:0]  sc_rd, sc_wdata;
  logic                sc_we;

  attn_ram #(.DEPTH(MAX_DIM), .WIDTH(SAMPLE_W)) u_qram (
    .clk, .we(s_acc && in_op == OP_LOAD_Q), .waddr(in_dim), .wdata(in_sample),
    .raddr(icnt[DIM_W-1:0]), .rdata(q_rd)
  );

  attn_ram #(.DEPTH(MAX_LEN * MAX_DIM), .WIDTH(SAMPLE_W)) u_kram (
    .clk, .we(s_acc && in_op == OP_LOAD_K), .waddr({in_pos, in_dim}), .wdata(in_sample),
    .raddr({j, icnt[DIM_W-1:0]}), .rdata(k_rd)
  );

  attn_ram #(.DEPTH(MAX_LEN * MAX_DIM), .WIDTH(SAMPLE_W)) u_vram (
    .clk, .we(s_acc && in_op == OP_LOAD_V), .waddr({in_pos, in_dim}), .wdata(in_sample),
    .raddr({icnt, d}), .rdata(v_rd)
  );

  attn_ram #(.DEPTH(MAX_LEN), .WIDTH(SCORE_W)) u_sram (
    .clk, .we(sc_we), .waddr(j), .wdata(sc_wdata),
    .raddr(out_phase ? icnt : j), .rdata(sc_rd)
  );

  // shared multiply-accumulate pipe
  logic signed [17:0]      op_a;
  logic signed [15:0]      op_b;
  logic signed [33:0]      prod;
  logic signed [ACC_W-1:0] acc;

  assign op_a = out_phase ? $signed({1'b0, sc_rd[WGT_W-1:0]}) : 18'(signed'(q_rd));
  assign op_b = out_phase ? $signed(v_rd) : $signed(k_rd);

  // scaling, weights, output
  logic [RS_W-1:0]          rs;
  logic [37:0]              plo;
  logic signed [38:0]       phi;
  logic signed [59:0]       full;
  logic signed [43:0]       sfl;
  logic signed [SCORE_W-1:0] ssat;
  logic signed [SCORE_W-1:0] mx;
  logic [32:0]              xdiff;
  logic                     big;
  logic [40:0]              yprod;
  logic [24:0]              y;
  logic [8:0]               en;
  logic [3:0]               ek;
  logic [11:0]              er;
  logic [WGT_W-1:0]         ta, tb, tdiff, w0, wexp, wgt;
  logic [23:0]              emul;
  logic                     masked;
  logic [DEN_W-1:0]         denom;
  logic                     neg;
  logic [ACC_W-1:0]         mag;
  logic [DIVN_W-1:0]        quo;
  logic signed [15:0]       oval;
  div_ctl_t                 dctl_in, dctl_out;

  assign rs    = RS_TAB[dim_m1];
  assign full  = (60'(phi) <<< 21) + 60'(signed'({1'b0, plo}));
  assign sfl   = full[59:16];
  always_comb begin
    if (sfl > 44'sd2147483647) ssat = 32'sh7FFFFFFF;
    else if (sfl < -44'sd2147483648) ssat = 32'sh80000000;
    else ssat = sfl[31:0];
  end

  assign xdiff = 33'(mx) - 33'(signed'(sc_rd));
  assign en    = y[24:16];
  assign ek    = y[15:12];
  assign er    = y[11:0];
  assign ta    = EXP2_TAB[ek];
  assign tb    = EXP2_TAB[5'(ek) + 5'd1];
  assign tdiff = ta - tb;
  assign emul  = tdiff[11:0] * er;
  assign w0    = ta - WGT_W'(emul[23:12]);
  assign wexp  = (big || en >= 9'd17) ? '0 : (w0 >> en[4:0]);
  assign masked = causal_mode && (j > qpos);
  assign wgt    = masked ? '0 : wexp;

  assign sc_we    = (state == ST_SC_WR) || (state == ST_W_EXP);
  assign sc_wdata = (state == ST_SC_WR) ? ssat : SCORE_W'(wgt);

  assign mag            = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign dctl_in.start  = (state == ST_DIV_LD);
  assign dctl_in.done   = 1'b0;

  attn_div u_div (
    .clk, .rst,
    .dividend(DIVN_W'(mag) + DIVN_W'(denom >> 1)),
    .divisor(denom),
    .ctl_in(dctl_in),
    .ctl_out(dctl_out),
    .quotient(quo)
  );

  always_comb begin
    if (neg) oval = (quo >= DIVN_W'(32768)) ? 16'sh8000 : 16'(-quo[15:0]);
    else     oval = (quo >= DIVN_W'(32767)) ? 16'sh7FFF : 16'(quo[15:0]);
  end

  // next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_acc && in_op == OP_COMPUTE) state_next = ST_DOT;
      ST_DOT:    if (v2 && l2) state_next = ST_SC_LO;
      ST_SC_LO:  state_next = ST_SC_HI;
      ST_SC_HI:  state_next = ST_SC_WR;
      ST_SC_WR:  state_next = (j == len_m1 || (causal_mode && j >= qpos)) ? ST_W_RD : ST_DOT;
      ST_W_RD:   state_next = ST_W_DAT;
      ST_W_DAT:  state_next = ST_W_EXP;
      ST_W_EXP:  state_next = (j == len_m1) ? ST_OUT : ST_W_RD;
      ST_OUT:    if (v2 && l2) state_next = ST_DIV_LD;
      ST_DIV_LD: state_next = ST_DIV;
      ST_DIV:    if (dctl_out.done) state_next = ST_EMIT;
      ST_EMIT: begin
        if (!m_tvalid || m_tready) state_next = (d == dim_m1) ? ST_IDLE : ST_OUT;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // control counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      v1 <= issuing;
      v2 <= v1;
      if ((state == ST_IDLE && state_next == ST_DOT) ||
          (state == ST_SC_WR && state_next == ST_DOT) ||
          (state == ST_W_EXP && state_next == ST_OUT) ||
          (state == ST_EMIT && state_next == ST_OUT)) begin
        issuing <= 1'b1;
      end else if (issuing && ilast) begin
        issuing <= 1'b0;
      end
      if (state == ST_EMIT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    l1   <= issuing && ilast;
    l2   <= l1;
    prod <= op_a * op_b;
    if (issuing) icnt <= icnt + 1'b1;
    if (v2) acc <= acc + ACC_W'(prod);

    case (state)
      ST_IDLE: begin
        qpos  <= in_pos;
        j     <= '0;
        d     <= '0;
        icnt  <= '0;
        acc   <= '0;
        denom <= '0;
      end
      ST_SC_LO: plo <= acc[20:0] * rs;
      ST_SC_HI: phi <= $signed(acc[ACC_W-1:21]) * $signed({1'b0, rs});
      ST_SC_WR: begin
        if (j == '0 || ssat > mx) mx <= ssat;
        icnt <= '0;
        acc  <= '0;
        if (state_next == ST_DOT) j <= j + 1'b1;
        else                      j <= '0;
      end
      ST_W_DAT: begin
        big   <= |xdiff[31:24];
        yprod <= xdiff[23:0] * LOG2E_Q16;
      end
      ST_W_EXP: begin
        denom <= denom + DEN_W'(wgt);
        j     <= j + 1'b1;
        icnt  <= '0;
        acc   <= '0;
      end
      ST_DIV_LD: neg <= acc[ACC_W-1];
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {2'b00, d, oval};
          m_tlast <= (d == dim_m1);
          d       <= d + 1'b1;
          icnt    <= '0;
          acc     <= '0;
        end
      end
      default: ;
    endcase
  end

  assign y = yprod[40:16];

endmodule

[design/attn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module attn_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[design/attn_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on attn_pkg for widths and the control struct.
module attn_div import attn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [DIVN_W-1:0] dividend,
  input  logic [DEN_W-1:0]  divisor,
  input  div_ctl_t          ctl_in,
  output div_ctl_t          ctl_out,
  output logic [DIVN_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVN_W + 1);

  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, quotient[DIVN_W-1]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVN_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DEN_W'(shifted - {1'b0, divisor}) : DEN_W'(shifted);
      quotient <= {quotient[DIVN_W-2:0], fits};
    end
  end

  assign ctl_out.start = ctl_in.start;
  assign ctl_out.done  = done;

endmodule

[design/attn_checker.sv]
// Port-level checker for attention_row_softmax, bound to the top level.
// Depends on attn_pkg for the port widths and the operation codes.
module attn_checker import attn_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  // stalled result word holds
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result word dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result word changed under stall");

  // a compute word closes the input until its row is done
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[1:0] == OP_COMPUTE |=> !s_tready)
    else $error("input open right after compute word");

  // nothing follows the last word of a row without a new compute
  a_row_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("result word after end of row");

endmodule

bind attention_row_softmax attn_checker u_attn_checker (
  .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
  .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
